[rtl/sat_pkg.sv]
// Shared constants for the sorted alarm table.
`timescale 1ns / 1ps
`default_nettype none
package sat_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;
  localparam logic [31:0] NO_ALARM = 32'hFFFF_FFFF;
  localparam logic [4:0] MAX_ENTRIES_RESET = 5'd10;
endpackage
`default_nettype wire

[rtl/sorted_alarm_table.sv]
// Top level of the sorted alarm table: entry store, sequencer and result register.
//
//  channel | signals                                          | handshake
//  in      | cmd alarm_key task_tag due_time now_time batch_last | in_valid / in_ready
//  out     | kind alarm_id alarm_task alarm_time entry_count    | out_valid / out_ready
//          | armed_count next_due last_result                  |
//  cfg     | max_entries_data                                  | max_entries_we
//
// A command walks the entries one per cycle through a single shared compare/move step
// unless an output stall holds it. Clear goes straight to its status item, remove and tick
// walk the table, add also makes room (dropping the earliest entry when the table is full)
// and inserts, and an add ending a batch trims. A fired alarm goes out in its tick step.
// in_ready is high only in the idle state. Output stalls hold the sequencer.
// Reset (rst, synchronous) empties the table and sets max_entries to ten.
`timescale 1ns / 1ps
`default_nettype none
module sorted_alarm_table #(
  parameter int DEPTH = 16,
  parameter int KEY_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] alarm_key,
  input  wire logic [15:0] task_tag,
  input  wire logic [31:0] due_time,
  input  wire logic [31:0] now_time,
  input  wire logic        batch_last,
  input  wire logic        max_entries_we,
  input  wire logic [4:0]  max_entries_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [15:0]      alarm_id,
  output logic [15:0]      alarm_task,
  output logic [31:0]      alarm_time,
  output logic [4:0]       entry_count,
  output logic [4:0]       armed_count,
  output logic [31:0]      next_due,
  output logic             last_result
);
  import sat_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DROP, S_FULL, S_POS, S_INS, S_TRIM, S_TICK, S_STAT, S_OUT
  } state_t;

  state_t state;
  logic [KEY_BITS-1:0] ekey [DEPTH];
  logic [15:0] etask [DEPTH];
  logic [31:0] edue [DEPTH];
  logic [DEPTH-1:0] eact;
  logic [CW-1:0] count;
  logic [4:0] max_entries;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [1:0] c_cmd;
  logic [KEY_BITS-1:0] c_key;
  logic [15:0] c_tag;
  logic [31:0] c_due;
  logic [31:0] c_now;
  logic c_last;
  logic [CW-1:0] act_cnt;
  logic [31:0] earliest;
  logic after_drop;

  logic [IW-1:0] ia;
  logic [IW-1:0] ib;
  logic fire_due;
  logic out_load;
  assign ia = idx[IW-1:0];
  assign ib = IW'(idx + CW'(1));
  assign in_ready = (state == S_IDLE);

  // Load the result register when an alarm or the status goes out
  assign fire_due = (state == S_TICK) && (idx < count) && (edue[ia] <= c_now) && eact[ia];
  assign out_load = (fire_due || (state == S_OUT)) && (!out_valid || out_ready);

  // Sequence one entry step per cycle unless an output stall holds it
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      eact <= '0;
      count <= '0;
      max_entries <= MAX_ENTRIES_RESET;
      out_valid <= 1'b0;
    end else begin
      if (max_entries_we) max_entries <= max_entries_data;
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_cmd <= cmd;
            c_key <= KEY_BITS'(alarm_key);
            c_tag <= task_tag;
            c_due <= due_time;
            c_now <= now_time;
            c_last <= batch_last;
            idx <= '0;
            case (cmd)
              CMD_CLEAR: begin
                count <= '0;
                eact <= '0;
                act_cnt <= '0;
                earliest <= NO_ALARM;
                state <= S_STAT;
              end
              CMD_TICK: state <= S_TICK;
              default: state <= S_FIND;
            endcase
          end
        end
        // Search for the key
        S_FIND: begin
          if (idx >= count) begin
            idx <= '0;
            pos <= '0;
            if (c_cmd == CMD_ADD) state <= S_FULL;
            else begin
              act_cnt <= '0;
              earliest <= NO_ALARM;
              state <= S_STAT;
            end
          end else if (ekey[ia] == c_key) begin
            after_drop <= 1'b0;
            state <= S_DROP;
          end else idx <= idx + CW'(1);
        end
        // Shift entries down over idx
        S_DROP: begin
          if (idx + CW'(1) >= count) begin
            count <= count - CW'(1);
            eact[ia] <= 1'b0;
            idx <= '0;
            pos <= '0;
            if (after_drop) state <= S_TRIM;
            else if (c_cmd == CMD_ADD) state <= S_FULL;
            else begin
              act_cnt <= '0;
              earliest <= NO_ALARM;
              state <= S_STAT;
            end
          end else begin
            ekey[ia] <= ekey[ib];
            etask[ia] <= etask[ib];
            edue[ia] <= edue[ib];
            eact[ia] <= eact[ib];
            idx <= idx + CW'(1);
          end
        end
        // Drop the earliest entry when the table is full
        S_FULL: begin
          if (count >= CW'(DEPTH)) begin
            after_drop <= 1'b0;
            idx <= '0;
            state <= S_DROP;
          end else state <= S_POS;
        end
        // Find insert position after equal times
        S_POS: begin
          if (pos < count && edue[pos[IW-1:0]] <= c_due) pos <= pos + CW'(1);
          else begin
            idx <= count;
            state <= S_INS;
          end
        end
        // Shift entries up then place the new one
        S_INS: begin
          if (idx > pos) begin
            ekey[ia] <= ekey[IW'(idx - CW'(1))];
            etask[ia] <= etask[IW'(idx - CW'(1))];
            edue[ia] <= edue[IW'(idx - CW'(1))];
            eact[ia] <= eact[IW'(idx - CW'(1))];
            idx <= idx - CW'(1);
          end else begin
            ekey[ia] <= c_key;
            etask[ia] <= c_tag;
            edue[ia] <= c_due;
            eact[ia] <= c_due > c_now;
            count <= count + CW'(1);
            state <= S_TRIM;
          end
        end
        // At a batch end, drop the earliest entries down to max_entries
        S_TRIM: begin
          idx <= '0;
          if (c_last && 32'(count) > 32'(max_entries)) begin
            after_drop <= 1'b1;
            state <= S_DROP;
          end else begin
            act_cnt <= '0;
            earliest <= NO_ALARM;
            state <= S_STAT;
          end
        end
        // Fire due entries one at a time
        S_TICK: begin
          if (idx < count && edue[ia] <= c_now) begin
            if (eact[ia]) begin
              if (!out_valid || out_ready) begin
                out_valid <= 1'b1;
                kind <= 1'b1;
                alarm_id <= 16'(ekey[ia]);
                alarm_task <= etask[ia];
                alarm_time <= edue[ia];
                entry_count <= '0;
                armed_count <= '0;
                next_due <= '0;
                last_result <= 1'b0;
                eact[ia] <= 1'b0;
                idx <= idx + CW'(1);
              end
            end else idx <= idx + CW'(1);
          end else begin
            idx <= '0;
            act_cnt <= '0;
            earliest <= NO_ALARM;
            state <= S_STAT;
          end
        end
        // Count active entries and find earliest time
        S_STAT: begin
          if (idx < count) begin
            if (eact[ia]) begin
              act_cnt <= act_cnt + CW'(1);
              if (edue[ia] < earliest) earliest <= edue[ia];
            end
            idx <= idx + CW'(1);
          end else state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            kind <= 1'b0;
            alarm_id <= '0;
            alarm_task <= '0;
            alarm_time <= '0;
            entry_count <= 5'(count);
            armed_count <= 5'(act_cnt);
            next_due <= earliest;
            last_result <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/sv/tb_sorted_alarm_table.sv]
// Self-checking testbench for the sorted alarm table.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_alarm_table;
  import sat_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        kind;
    logic [15:0] alarm_id;
    logic [15:0] alarm_task;
    logic [31:0] alarm_time;
    logic [4:0]  entry_count;
    logic [4:0]  armed_count;
    logic [31:0] next_due;
    logic        last_result;
  } alarm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = CMD_ADD;
  logic [15:0] alarm_key = '0;
  logic [15:0] task_tag = '0;
  logic [31:0] due_time = '0;
  logic [31:0] now_time = '0;
  logic batch_last = 1'b0;
  logic max_entries_we = 1'b0;
  logic [4:0] max_entries_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [15:0] alarm_id;
  logic [15:0] alarm_task;
  logic [31:0] alarm_time;
  logic [4:0] entry_count;
  logic [4:0] armed_count;
  logic [31:0] next_due;
  logic last_result;

  // Predicted table contents
  logic [15:0] tbl_key[DEPTH];
  logic [15:0] tbl_tag[DEPTH];
  logic [31:0] tbl_due[DEPTH];
  logic        tbl_act[DEPTH];
  int          tbl_count;
  logic [4:0]  keep_limit;

  alarm_result_t pending_results[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_off = 0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  sorted_alarm_table #(.DEPTH(DEPTH), .KEY_BITS(16)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .alarm_key(alarm_key), .task_tag(task_tag), .due_time(due_time),
    .now_time(now_time), .batch_last(batch_last),
    .max_entries_we(max_entries_we), .max_entries_data(max_entries_data),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .alarm_id(alarm_id), .alarm_task(alarm_task), .alarm_time(alarm_time),
    .entry_count(entry_count), .armed_count(armed_count),
    .next_due(next_due), .last_result(last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void table_drop(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_key[i] = tbl_key[i + 1];
      tbl_tag[i] = tbl_tag[i + 1];
      tbl_due[i] = tbl_due[i + 1];
      tbl_act[i] = tbl_act[i + 1];
    end
    tbl_count--;
  endfunction

  function automatic void table_drop_key(logic [15:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) begin
        table_drop(i);
        return;
      end
    end
  endfunction

  // Work out the results of one command and advance the predicted table
  function automatic void predict_alarms(logic [1:0] c, logic [15:0] key, logic [15:0] tag,
                                         logic [31:0] due, logic [31:0] now, logic last);
    alarm_result_t r;
    int pos;
    int act;
    logic [31:0] earliest;
    pos = 0;
    act = 0;
    earliest = NO_ALARM;
    case (c)
      CMD_ADD: begin
        table_drop_key(key);
        if (tbl_count >= DEPTH) table_drop(0);
        while (pos < tbl_count && tbl_due[pos] <= due) pos++;
        for (int i = tbl_count; i > pos; i--) begin
          tbl_key[i] = tbl_key[i - 1];
          tbl_tag[i] = tbl_tag[i - 1];
          tbl_due[i] = tbl_due[i - 1];
          tbl_act[i] = tbl_act[i - 1];
        end
        tbl_key[pos] = key;
        tbl_tag[pos] = tag;
        tbl_due[pos] = due;
        tbl_act[pos] = due > now;
        tbl_count++;
        if (last) while (tbl_count > keep_limit) table_drop(0);
      end
      CMD_REMOVE: table_drop_key(key);
      CMD_CLEAR: begin
        tbl_count = 0;
        for (int i = 0; i < DEPTH; i++) tbl_act[i] = 1'b0;
      end
      default: begin
        for (int i = 0; i < tbl_count && tbl_due[i] <= now; i++) begin
          if (tbl_act[i]) begin
            r = '0;
            r.kind = 1'b1;
            r.alarm_id = tbl_key[i];
            r.alarm_task = tbl_tag[i];
            r.alarm_time = tbl_due[i];
            pending_results.push_back(r);
            tbl_act[i] = 1'b0;
          end
        end
      end
    endcase
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_act[i]) begin
        act++;
        if (tbl_due[i] < earliest) earliest = tbl_due[i];
      end
    end
    r = '0;
    r.entry_count = 5'(tbl_count);
    r.armed_count = 5'(act);
    r.next_due = earliest;
    r.last_result = 1'b1;
    pending_results.push_back(r);
  endfunction

  // Offer one item, then wait for it to be taken
  task automatic send_item(logic [1:0] c, logic [15:0] key, logic [15:0] tag,
                           logic [31:0] due, logic [31:0] now, logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    alarm_key <= key;
    task_tag <= tag;
    due_time <= due;
    now_time <= now;
    batch_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_alarms(c, key, tag, due, now, last);
    @(negedge clk);
  endtask

  // Drop valid and let every expected result come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Write the keep limit while the block is idle
  task automatic set_keep_limit(logic [4:0] value);
    wait_drained();
    max_entries_we <= 1'b1;
    max_entries_data <= value;
    @(negedge clk);
    max_entries_we <= 1'b0;
    keep_limit = value;
  endtask

  // Receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_off <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stalls_on || ($urandom_range(0, 9) < 7);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    alarm_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d", kind);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (kind !== exp_r.kind) begin
          $error("kind: expected %0h actual %0h", exp_r.kind, kind); fail_count++;
        end
        if (alarm_id !== exp_r.alarm_id) begin
          $error("alarm_id: expected %0h actual %0h", exp_r.alarm_id, alarm_id);
          fail_count++;
        end
        if (alarm_task !== exp_r.alarm_task) begin
          $error("alarm_task: expected %0h actual %0h", exp_r.alarm_task, alarm_task);
          fail_count++;
        end
        if (alarm_time !== exp_r.alarm_time) begin
          $error("alarm_time: expected %0h actual %0h", exp_r.alarm_time, alarm_time);
          fail_count++;
        end
        if (entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d actual %0d", exp_r.entry_count, entry_count);
          fail_count++;
        end
        if (armed_count !== exp_r.armed_count) begin
          $error("armed_count: expected %0d actual %0d", exp_r.armed_count, armed_count);
          fail_count++;
        end
        if (next_due !== exp_r.next_due) begin
          $error("next_due: expected %0h actual %0h", exp_r.next_due, next_due);
          fail_count++;
        end
        if (last_result !== exp_r.last_result) begin
          $error("last_result: expected %0h actual %0h", exp_r.last_result, last_result);
          fail_count++;
        end
      end
    end
  end

  // Field extremes, every command, full table, missing key, equal times
  task automatic test_directed();
    send_item(CMD_TICK, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0);
    send_item(CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_item(CMD_ADD, 16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_ADD, 16'h1234, 16'hAAAA, 32'd100, 32'd50, 1'b0);
    send_item(CMD_ADD, 16'h4321, 16'h5555, 32'd100, 32'd50, 1'b0);
    send_item(CMD_ADD, 16'h1234, 16'h0F0F, 32'd200, 32'd50, 1'b1);
    send_item(CMD_REMOVE, 16'h7777, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_TICK, 16'h0, 16'h0, 32'h0, 32'd150, 1'b0);
    send_item(CMD_REMOVE, 16'h4321, 16'h0, 32'h0, 32'h0, 1'b0);
    send_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // Overfill so the earliest entry is pushed out
    for (int i = 0; i < 18; i++)
      send_item(CMD_ADD, 16'(i), 16'(i * 3), 32'(1000 + i), 32'd10, 1'b0);
    send_item(CMD_TICK, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
  endtask

  // Walk the keep limit across its extremes with batched adds
  task automatic test_keep_limit();
    logic [4:0] limits[5] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd5};
    foreach (limits[j]) begin
      set_keep_limit(limits[j]);
      send_item(CMD_CLEAR, 16'h0, 16'h0, 32'h0, 32'h0, 1'b0);
      for (int i = 0; i < 8; i++)
        send_item(CMD_ADD, 16'($urandom), 16'($urandom), 32'($urandom_range(0, 50)),
                  32'd20, i == 7);
      send_item(CMD_TICK, 16'h0, 16'h0, 32'h0, 32'd60, 1'b0);
    end
  endtask

  // Mostly add batches on a small key space, with removes and ticks in between
  task automatic test_random(int n_items);
    logic [31:0] now;
    logic [1:0] c;
    int pick;
    now = 32'd1000;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      c = pick < 60 ? CMD_ADD : pick < 75 ? CMD_REMOVE : pick < 78 ? CMD_CLEAR : CMD_TICK;
      if ($urandom_range(0, 3) == 0) now = now + $urandom_range(0, 40);
      if ($urandom_range(0, 30) == 0) now = $urandom;
      send_item(c,
                $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 23)),
                16'($urandom),
                $urandom_range(0, 7) == 0 ? $urandom : now + $urandom_range(0, 80) - 20,
                now, $urandom_range(0, 5) == 0);
      if (i == n_items / 2) begin
        gaps_on = ~gaps_on;
        stalls_on = ~stalls_on;
      end
    end
  endtask

  // Hold the receiver off while a batch of items queues up behind it
  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 6; i++)
      send_item(CMD_ADD, 16'(i + 40), 16'(i), 32'd5, 32'd0, 1'b0);
    send_item(CMD_TICK, 16'h0, 16'h0, 32'h0, 32'd10, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) tbl_act[i] = 1'b0;
    tbl_count = 0;
    keep_limit = MAX_ENTRIES_RESET;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_keep_limit();
    set_keep_limit(5'd10);
    test_random(200);
    test_backpressure();
    set_keep_limit(5'd16);
    test_random(150);
    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
